>>> rtl/eswe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package eswe_pkg;

  // Queue sizing
  localparam int unsigned QueueDepthDef  = 512;
  localparam int unsigned QueueLimitBase = 500;

  // Status word layout
  localparam int unsigned RangeBitPos = 28;
  localparam int unsigned TrigLsb     = 8;
  localparam int unsigned TrigW       = 16;
  localparam int unsigned WordW       = 32;

  // Configuration port
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 24;
  localparam logic [CfgAddrW-1:0] RegRefresh    = 2'd0;
  localparam logic [CfgAddrW-1:0] RegSplit      = 2'd1;
  localparam logic [CfgAddrW-1:0] RegDecimation = 2'd2;

  localparam logic [3:0] DeciMax = 4'd8;

  // Result kinds, carried on tuser
  typedef enum logic [2:0] {
    KIND_STATUS = 3'd0,
    KIND_RANGE  = 3'd1,
    KIND_TRIG   = 3'd2,
    KIND_HIGH   = 3'd3,
    KIND_LOW    = 3'd4
  } kind_e;

  // Where the status beat of an item takes its value from
  typedef enum logic [2:0] {
    SRC_RAW  = 3'd0,  // raw input word, no decimation
    SRC_HELD = 3'd1,  // held word, not a pop phase
    SRC_MEM  = 3'd2,  // popped word from queue memory read data
    SRC_ZERO = 3'd3,  // popped zero entry or empty queue
    SRC_FWD  = 3'd4   // popped the word pushed by this same item
  } stat_src_e;

  typedef struct packed {
    kind_e            kind;
    logic [TrigW-1:0] val;
  } ev_t;

  // One accepted item, as handed to the beat sequencer
  typedef struct packed {
    ev_t [2:0]        ev;
    logic [1:0]       n_ev;
    stat_src_e        src;
    logic [WordW-1:0] word;
    logic [WordW-1:0] idx;
    logic             ovf;
  } item_t;

  // Queue requests of one accepted item
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

endpackage

`default_nettype wire

>>> rtl/eswe_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module eswe_queue import eswe_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire q_ctl_t           ctl_i,
  input  wire logic [WordW-1:0] wdata_i,
  output logic                  full_o,
  output stat_src_e             src_o,
  output logic [WordW-1:0]      rdata_o
);

  // Entries come in pairs (word, zero); only the word of each pair is stored.
  localparam int unsigned Limit = (QUEUE_DEPTH < QueueLimitBase) ? QUEUE_DEPTH : QueueLimitBase;
  localparam int unsigned Pairs = (Limit + 1) / 2;
  localparam int unsigned AW    = (Pairs > 1) ? $clog2(Pairs) : 1;
  localparam int unsigned CW    = $clog2(Limit + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Pairs - 1);

  logic [WordW-1:0] mem [Pairs];
  logic [WordW-1:0] rdata_q;

  logic [AW-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          half_q, half_d;  // head sits on the zero entry of its pair

  logic push_ok, pop_eff, rd_en;

  assign full_o  = ({1'b0, cnt_q} + (CW+1)'(2)) > (CW+1)'(Limit);
  assign push_ok = ctl_i.push && !full_o;
  assign pop_eff = ctl_i.pop && ((cnt_q != '0) || push_ok);
  assign rd_en   = ctl_i.pop && (cnt_q != '0) && !half_q;

  // Pop source, push is ordered before pop
  always_comb begin
    if (cnt_q == '0) begin
      src_o = push_ok ? SRC_FWD : SRC_ZERO;
    end else if (half_q) begin
      src_o = SRC_ZERO;
    end else begin
      src_o = SRC_MEM;
    end
  end

  // Pointer and count update
  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    half_d = half_q;
    cnt_d  = cnt_q;
    if (push_ok) begin
      wr_d  = (wr_q == LastPtr) ? '0 : wr_q + AW'(1);
      cnt_d = cnt_d + CW'(2);
    end
    if (pop_eff) begin
      cnt_d = cnt_d - CW'(1);
      if (half_q) begin
        half_d = 1'b0;
        rd_d   = (rd_q == LastPtr) ? '0 : rd_q + AW'(1);
      end else begin
        half_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      half_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      half_q <= half_d;
      cnt_q  <= cnt_d;
    end
  end

  // Word memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_q];
    end
  end

  assign rdata_o = rdata_q;

  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Limit))
    else $error("queue count above limit");

  a_empty_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !half_q)
    else $error("empty queue with head on zero entry");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_ok && !pop_eff) |=> (cnt_q == $past(cnt_q) + CW'(2)))
    else $error("push did not add a pair");

endmodule

`default_nettype wire

>>> rtl/eswe_beat_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module eswe_beat_seq import eswe_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire item_t            item_i,
  input  wire logic [WordW-1:0] rdata_i,
  output logic                  free_o,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [71:0]           m_axis_tdata,  // value[31:0], sample_index[63:32], overflow[64]
  output logic [2:0]            m_axis_tuser,  // kind[2:0]
  output logic                  m_axis_tlast
);

  item_t            rec_q;
  logic             rec_vld_q;
  logic [1:0]       beat_q;
  logic [WordW-1:0] held_q;

  logic             out_vld_q, out_last_q, out_ovf_q;
  kind_e            out_kind_q;
  logic [WordW-1:0] out_val_q, out_idx_q;

  logic             move, last_beat, held_upd;
  logic [WordW-1:0] stat_val;
  kind_e            beat_kind;
  logic [WordW-1:0] beat_val;

  assign move      = rec_vld_q && (!out_vld_q || m_axis_tready);
  assign last_beat = (beat_q == rec_q.n_ev);
  assign free_o    = !rec_vld_q || (move && last_beat);

  // Status value of the current record
  always_comb begin
    case (rec_q.src)
      SRC_RAW:  stat_val = rec_q.word;
      SRC_FWD:  stat_val = rec_q.word;
      SRC_HELD: stat_val = held_q;
      SRC_MEM:  stat_val = rdata_i;
      SRC_ZERO: stat_val = '0;
      default:  stat_val = '0;
    endcase
  end

  assign held_upd = move && last_beat &&
                    ((rec_q.src == SRC_FWD) || (rec_q.src == SRC_MEM) ||
                     (rec_q.src == SRC_ZERO));

  // Current beat: events first, status last
  always_comb begin
    if (last_beat) begin
      beat_kind = KIND_STATUS;
      beat_val  = stat_val;
    end else begin
      beat_kind = rec_q.ev[beat_q].kind;
      beat_val  = {{(WordW-TrigW){1'b0}}, rec_q.ev[beat_q].val};
    end
  end

  // Record slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_vld_q <= 1'b0;
      beat_q    <= '0;
      held_q    <= '0;
    end else begin
      if (held_upd) begin
        held_q <= stat_val;
      end
      if (load_i) begin
        rec_vld_q <= 1'b1;
        beat_q    <= '0;
      end else if (move) begin
        if (last_beat) begin
          rec_vld_q <= 1'b0;
          beat_q    <= '0;
        end else begin
          beat_q <= beat_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q <= item_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (move) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_kind_q <= beat_kind;
      out_val_q  <= beat_val;
      out_idx_q  <= rec_q.idx;
      out_ovf_q  <= rec_q.ovf;
      out_last_q <= last_beat;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_ovf_q, out_idx_q, out_val_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  a_beat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_vld_q |-> (beat_q <= rec_q.n_ev))
    else $error("beat index past record");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("record loaded while busy");

endmodule

`default_nettype wire

>>> rtl/eeg_status_word_event_extractor.sv
// The first result beat of an accepted input beat is registered in the record slot, then in the
// output register. Throughput: one result beat per cycle while m_axis_tready is high; an item
// with n results (1 to 4) holds the input until its last beat moves to the output register, so
// single-result items stream one per cycle while m_axis_tready is high.
// Reset (rst_ni low, asynchronous) clears all control and state registers; the trigger
// queue memory is not cleared and needs no clearing pass, entries are read only after written.
`timescale 1ns / 1ps
`default_nettype none

module eeg_status_word_event_extractor import eswe_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [31:0]         s_axis_tdata,  // status_word[31:0]
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [71:0]              m_axis_tdata,  // value, sample_index, overflow
  output logic [2:0]               m_axis_tuser,  // kind[2:0]
  output logic                     m_axis_tlast
);

  // Configuration registers
  logic [23:0] refresh_q;
  logic        split_q;
  logic [3:0]  deci_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refresh_q <= '0;
      split_q   <= 1'b0;
      deci_q    <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegRefresh:    refresh_q <= cfg_data_i;
        RegSplit:      split_q   <= cfg_data_i[0];
        RegDecimation: deci_q    <= cfg_data_i[3:0];
        default:       ;
      endcase
    end
  end

  // Scalar state
  logic             range_q, range_d;
  logic [23:0]      cd_q, cd_d;
  logic [TrigW-1:0] prev_q;
  logic [2:0]       phase_q, phase_d;
  logic [WordW-1:0] smp_q;
  logic             ovf_q, ovf_d;

  logic             accept, free;
  logic [3:0]       deci;
  logic             deci_on, range_bit, range_ev, trig_chg;
  logic [TrigW-1:0] trig;
  q_ctl_t           q_ctl;
  stat_src_e        q_src;
  logic             q_full;
  logic [WordW-1:0] q_rdata;
  item_t            item;

  assign s_axis_tready = free;
  assign accept        = s_axis_tvalid && free;

  assign deci    = (deci_q == 4'd0) ? 4'd1 : ((deci_q > DeciMax) ? DeciMax : deci_q);
  assign deci_on = deci > 4'd1;

  assign range_bit = ~s_axis_tdata[RangeBitPos];
  assign range_ev  = (cd_q == '0) || (range_bit != range_q);
  assign trig      = s_axis_tdata[TrigLsb +: TrigW];
  assign trig_chg  = (trig != '0) && (trig != prev_q);

  assign q_ctl.push = accept && trig_chg && deci_on;
  assign q_ctl.pop  = accept && deci_on && (phase_q == 3'd0);

  // Next scalar state
  always_comb begin
    range_d = range_q;
    cd_d    = cd_q - 24'd1;
    if (range_ev) begin
      range_d = range_bit;
      cd_d    = refresh_q;
    end
    ovf_d   = ovf_q || (q_ctl.push && q_full);
    phase_d = ({1'b0, phase_q} + 4'd1 >= deci) ? 3'd0 : phase_q + 3'd1;
  end

  // Build the item record, events in result order
  always_comb begin
    logic [1:0] n;
    n = 2'd0;
    item.ev = '0;
    if (range_ev) begin
      item.ev[n].kind = KIND_RANGE;
      item.ev[n].val  = {{(TrigW-1){1'b0}}, range_bit};
      n = n + 2'd1;
    end
    if (trig_chg) begin
      if (!split_q) begin
        item.ev[n].kind = KIND_TRIG;
        item.ev[n].val  = trig;
        n = n + 2'd1;
      end else begin
        if (trig[15:8] != prev_q[15:8]) begin
          item.ev[n].kind = KIND_HIGH;
          item.ev[n].val  = {8'd0, trig[15:8]};
          n = n + 2'd1;
        end
        if (trig[7:0] != prev_q[7:0]) begin
          item.ev[n].kind = KIND_LOW;
          item.ev[n].val  = {8'd0, trig[7:0]};
          n = n + 2'd1;
        end
      end
    end
    item.n_ev = n;
    if (!deci_on) begin
      item.src = SRC_RAW;
    end else if (phase_q == 3'd0) begin
      item.src = q_src;
    end else begin
      item.src = SRC_HELD;
    end
    item.word = s_axis_tdata;
    item.idx  = smp_q;
    item.ovf  = ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= 1'b0;
      cd_q    <= '0;
      prev_q  <= '0;
      phase_q <= '0;
      smp_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (accept) begin
      range_q <= range_d;
      cd_q    <= cd_d;
      prev_q  <= trig;
      phase_q <= phase_d;
      smp_q   <= smp_q + 32'd1;
      ovf_q   <= ovf_d;
    end
  end

  eswe_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (q_ctl),
    .wdata_i(s_axis_tdata),
    .full_o (q_full),
    .src_o  (q_src),
    .rdata_o(q_rdata)
  );

  eswe_beat_seq u_beat_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .item_i       (item),
    .rdata_i      (q_rdata),
    .free_o       (free),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ({1'b0, phase_q} < $past(deci)))
    else $error("phase outside decimation factor");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import eswe_pkg::*;

  // One output beat: kind on tuser, value/index/overflow on tdata, last on tlast
  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic [31:0] idx;
    logic        ovf;
    logic        last;
  } beat_t;

  localparam int unsigned QLimit =
      (QueueDepthDef < QueueLimitBase) ? QueueDepthDef : QueueLimitBase;

  // Predicts the beats of each accepted sample and checks what comes out
  class status_event_scoreboard;
    int unsigned errors;
    beat_t       pending_beats[$];
    // configuration copy
    logic [23:0] refresh_len;
    logic        split_on;
    logic [3:0]  deci_reg;
    // block state copy
    logic        range_flag;
    logic [23:0] countdown;
    logic [15:0] prev_trig;
    logic [31:0] trig_fifo[$];
    int unsigned phase;
    logic [31:0] held_word;
    logic [31:0] sample_cnt;
    logic        ovf_flag;

    function new();
      errors      = 0;
      refresh_len = '0;
      split_on    = 1'b0;
      deci_reg    = 4'd1;
      range_flag  = 1'b0;
      countdown   = '0;
      prev_trig   = '0;
      phase       = 0;
      held_word   = '0;
      sample_cnt  = '0;
      ovf_flag    = 1'b0;
    endfunction

    function void write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
      case (addr)
        RegRefresh:    refresh_len = data[23:0];
        RegSplit:      split_on    = data[0];
        RegDecimation: deci_reg    = data[3:0];
        default: ;
      endcase
    endfunction

    function beat_t mk(kind_e k, logic [31:0] v);
      beat_t b;
      b.kind  = k;
      b.value = v;
      b.idx   = sample_cnt;
      b.ovf   = 1'b0;
      b.last  = 1'b0;
      return b;
    endfunction

    function void predict_sample(logic [31:0] word);
      beat_t       beats[$];
      int unsigned deci;
      logic        rb;
      logic [15:0] trig;
      logic [31:0] status_out;
      deci = (deci_reg == 0) ? 1 : ((deci_reg > DeciMax) ? DeciMax : deci_reg);

      // range report on change or when the refresh count runs out
      rb = ~word[RangeBitPos];
      if (countdown == 0 || rb != range_flag) begin
        beats.push_back(mk(KIND_RANGE, {31'b0, rb}));
        range_flag = rb;
        countdown  = refresh_len;
      end else begin
        countdown = countdown - 24'd1;
      end

      // trigger events and queue push
      trig = word[TrigLsb +: TrigW];
      if (trig != 0 && trig != prev_trig) begin
        if (!split_on) begin
          beats.push_back(mk(KIND_TRIG, {16'b0, trig}));
        end else begin
          if (trig[15:8] != prev_trig[15:8]) beats.push_back(mk(KIND_HIGH, {24'b0, trig[15:8]}));
          if (trig[7:0] != prev_trig[7:0]) beats.push_back(mk(KIND_LOW, {24'b0, trig[7:0]}));
        end
        if (deci > 1) begin
          if (trig_fifo.size() + 2 > QLimit) begin
            ovf_flag = 1'b1;
          end else begin
            trig_fifo.push_back(word);
            trig_fifo.push_back(32'b0);
          end
        end
      end
      prev_trig = trig;

      // status beat: raw word, or held word popped at phase zero
      if (deci > 1) begin
        if (phase == 0) held_word = (trig_fifo.size() > 0) ? trig_fifo.pop_front() : 32'b0;
        status_out = held_word;
      end else begin
        status_out = word;
      end
      beats.push_back(mk(KIND_STATUS, status_out));

      foreach (beats[i]) beats[i].ovf = ovf_flag;
      beats[beats.size()-1].last = 1'b1;
      foreach (beats[i]) pending_beats.push_back(beats[i]);

      phase      = (phase + 1 >= deci) ? 0 : phase + 1;
      sample_cnt = sample_cnt + 32'd1;
    endfunction

    function void check_beat(beat_t got);
      beat_t want;
      if (pending_beats.size() == 0) begin
        $display("%0t: beat with nothing expected: kind %0d value %h idx %0d",
                 $time, got.kind, got.value, got.idx);
        errors++;
        return;
      end
      want = pending_beats.pop_front();
      if (got.kind != want.kind) begin
        $display("%0t: kind mismatch: expected %0d actual %0d", $time, want.kind, got.kind);
        errors++;
      end
      if (got.value != want.value) begin
        $display("%0t: value mismatch: expected %h actual %h", $time, want.value, got.value);
        errors++;
      end
      if (got.idx != want.idx) begin
        $display("%0t: index mismatch: expected %0d actual %0d", $time, want.idx, got.idx);
        errors++;
      end
      if (got.ovf != want.ovf) begin
        $display("%0t: overflow mismatch: expected %b actual %b", $time, want.ovf, got.ovf);
        errors++;
      end
      if (got.last != want.last) begin
        $display("%0t: last mismatch: expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_beats.size();
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [71:0]         m_axis_tdata;
  logic [2:0]          m_axis_tuser;
  logic                m_axis_tlast;

  status_event_scoreboard sb;
  logic        quiet     = 1'b0;
  logic [15:0] last_trig = '0;
  logic        last_rng  = 1'b0;

  eeg_status_word_event_extractor dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Idle cycles before a beat; none at all in quiet stretches
  function automatic int unsigned draw_gap();
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  // Random status word: mostly fresh triggers, some repeats, zeros, single-byte changes
  function automatic logic [31:0] make_word();
    logic [31:0] w;
    logic [15:0] t;
    int unsigned pick;
    w    = $urandom;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       t = last_trig;
      1:       t = '0;
      2:       t = {last_trig[15:8] ^ 8'($urandom_range(1, 255)), last_trig[7:0]};
      3:       t = {last_trig[15:8], last_trig[7:0] ^ 8'($urandom_range(1, 255))};
      default: t = 16'($urandom_range(1, 65535));
    endcase
    if ($urandom_range(0, 4) == 0) last_rng = ~last_rng;
    w[TrigLsb +: TrigW] = t;
    w[RangeBitPos]      = last_rng;
    last_trig           = t;
    return w;
  endfunction

  task automatic send_sample(input logic [31:0] w);
    int unsigned g;
    g = draw_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.predict_sample(w);
  endtask

  // Stop sending and wait until every expected beat has been seen
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] a, input logic [CfgDataW-1:0] d);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= a;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(a, d);
  endtask

  task automatic recv_beat();
    int unsigned g;
    beat_t       got;
    g = draw_gap();
    if (g > 0) begin
      m_axis_tready <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    m_axis_tready <= 1'b1;
    @(posedge clk_i);
    while (!m_axis_tvalid) @(posedge clk_i);
    got.kind  = kind_e'(m_axis_tuser);
    got.value = m_axis_tdata[31:0];
    got.idx   = m_axis_tdata[63:32];
    got.ovf   = m_axis_tdata[64];
    got.last  = m_axis_tlast;
    sb.check_beat(got);
  endtask

  task automatic run_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_sample(make_word());
  endtask

  // Output side
  initial begin
    wait (rst_ni === 1'b1);
    forever recv_beat();
  end

  // Stimulus
  initial begin
    logic [31:0] plain_words[11];
    logic [31:0] split_words[5];
    plain_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1000_0000, 32'hEFFF_FFFF,
                    32'h0000_0100, 32'h00FF_FF00, 32'h00FF_FF00, 32'h0000_0000,
                    32'h00FF_FF00, 32'hAAAA_AAAA, 32'h5555_5555};
    split_words = '{32'h0012_3400, 32'h0012_5600, 32'h00AB_5600,
                    32'h00CD_7800, 32'h00CD_7800};
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: no decimation, range report every sample
    foreach (plain_words[i]) send_sample(plain_words[i]);
    // Split bytes: both, low only, high only, both, unchanged
    write_reg(RegSplit, 24'd1);
    foreach (split_words[i]) send_sample(split_words[i]);

    write_reg(RegRefresh, 24'd3);
    write_reg(RegDecimation, 24'd3);
    run_random(40);
    drain();
    run_random(40);

    // Decimation zero acts as one; longest refresh
    write_reg(RegRefresh, 24'hFF_FFFF);
    write_reg(RegSplit, 24'd0);
    write_reg(RegDecimation, 24'd0);
    quiet = 1'b1;
    run_random(50);
    quiet = 1'b0;

    // Decimation above the top clamps to eight
    write_reg(RegRefresh, 24'd1);
    write_reg(RegSplit, 24'd1);
    write_reg(RegDecimation, 24'd15);
    run_random(80);

    write_reg(RegRefresh, 24'($urandom_range(0, 7)));
    write_reg(RegSplit, 24'd0);
    write_reg(RegDecimation, 24'd5);
    run_random(60);

    // Long run at full decimation to push the queue past its limit
    write_reg(RegRefresh, 24'd2);
    write_reg(RegSplit, 24'd1);
    write_reg(RegDecimation, 24'd8);
    quiet = 1'b1;
    run_random(50);
    quiet = 1'b0;
    run_random(120);

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

>>> files.f
rtl/eswe_pkg.sv
rtl/eswe_queue.sv
rtl/eswe_beat_seq.sv
rtl/eeg_status_word_event_extractor.sv
tb/tb_top.sv
